// ----- src/wav_pcm_stream_parser_assert.svh -----
// assertion macros used by the wav parser engine
`ifndef WAV_PCM_STREAM_PARSER_ASSERT_SVH
`define WAV_PCM_STREAM_PARSER_ASSERT_SVH

// same-cycle implication
`define WPP_ASSERT_IMP(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");

// next-cycle implication
`define WPP_ASSERT_NXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");

`endif

// ----- src/wpp_pkg.sv -----
// types and constants of the wav pcm stream parser
package wpp_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] sample;
    logic [14:0]        channel;
    logic [31:0]        frame_index;
    logic [1:0]         sample_bits;
    logic [3:0]         error_code;
    logic [31:0]        frames_read;
    logic               last;
  } out_item_t;

  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_ERROR  = 2'd1;
  localparam logic [1:0] KIND_DONE   = 2'd2;

  localparam logic [3:0] ERR_RIFF     = 4'd0;
  localparam logic [3:0] ERR_WAVE     = 4'd1;
  localparam logic [3:0] ERR_FMT_MARK = 4'd2;
  localparam logic [3:0] ERR_FMT_SIZE = 4'd3;
  localparam logic [3:0] ERR_TAG      = 4'd4;
  localparam logic [3:0] ERR_CHANNELS = 4'd5;
  localparam logic [3:0] ERR_BITS     = 4'd6;
  localparam logic [3:0] ERR_ALIGN    = 4'd7;
  localparam logic [3:0] ERR_BLOCK    = 4'd8;

  localparam logic [31:0] MARK_RIFF = 32'h4646_4952;
  localparam logic [31:0] MARK_WAVE = 32'h4556_4157;
  localparam logic [31:0] MARK_FMT  = 32'h2074_6D66;
  localparam logic [31:0] MARK_DATA = 32'h6174_6164;

  localparam logic [15:0] TAG_PCM        = 16'h0001;
  localparam logic [15:0] TAG_EXTENSIBLE = 16'hFFFE;

  localparam logic [31:0] FMT_LEN_16 = 32'd16;
  localparam logic [31:0] FMT_LEN_18 = 32'd18;
  localparam logic [31:0] FMT_LEN_40 = 32'd40;

  localparam logic [15:0] BITS_8  = 16'd8;
  localparam logic [15:0] BITS_16 = 16'd16;
  localparam logic [15:0] BITS_24 = 16'd24;

  // header byte offsets that complete a field
  localparam logic [5:0] POS_RIFF_MARK = 6'd3;
  localparam logic [5:0] POS_RIFF_SIZE = 6'd7;
  localparam logic [5:0] POS_WAVE_MARK = 6'd11;
  localparam logic [5:0] POS_FMT_MARK  = 6'd15;
  localparam logic [5:0] POS_FMT_SIZE  = 6'd19;
  localparam logic [5:0] POS_TAG       = 6'd21;
  localparam logic [5:0] POS_CHANNELS  = 6'd23;
  localparam logic [5:0] POS_BLOCK     = 6'd33;
  localparam logic [5:0] POS_BITS      = 6'd35;

  localparam logic CFG_FIRST_FRAME = 1'b0;
  localparam logic CFG_STOP_FRAME  = 1'b1;

  typedef enum logic [6:0] {
    PH_HEADER = 7'b0000001,
    PH_EXT    = 7'b0000010,
    PH_CHUNK  = 7'b0000100,
    PH_SKIP   = 7'b0001000,
    PH_DATA   = 7'b0010000,
    PH_CHECK  = 7'b0100000,
    PH_HALT   = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic       room;
    logic [1:0] cnt;
  } res_ctl_t;

endpackage

// ----- src/wpp_inq.sv -----
// two-entry input byte queue in front of the parser engine
module wpp_inq (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  wpp_pkg::in_item_t  din,
  output logic               full,
  input  logic               take,
  output logic               valid,
  output wpp_pkg::in_item_t  dout
);
  wpp_pkg::in_item_t ent [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_take;

  assign full    = (count == 2'd2);
  assign valid   = (count != 2'd0);
  assign dout    = ent[rd_ptr];
  assign do_push = push && !full;
  assign do_take = take && valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_take) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_take};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) ent[wr_ptr] <= din;
  end
endmodule

// ----- src/wpp_outq.sv -----
// four-entry result queue, takes up to two results per cycle
module wpp_outq (
  input  logic               clk,
  input  logic               rst,
  input  logic [1:0]         push_n,
  input  wpp_pkg::out_item_t d0,
  input  wpp_pkg::out_item_t d1,
  output logic               room,
  input  logic               pop,
  output logic               empty,
  output wpp_pkg::out_item_t dout
);
  wpp_pkg::out_item_t ent [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic       do_pop;

  assign empty  = (count == 3'd0);
  assign room   = (count <= 3'd2);
  assign dout   = ent[rd_ptr];
  assign do_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr + push_n;
      if (do_pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count + {1'b0, push_n} - {2'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) ent[wr_ptr] <= d0;
    if (push_n == 2'd2) ent[wr_ptr + 2'd1] <= d1;
  end
endmodule

// ----- src/wpp_mod.sv -----
// restoring remainder unit, one dividend bit per cycle
module wpp_mod (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        busy,
  output logic        done,
  output logic        rem_zero
);
  logic [31:0] shreg;
  logic [15:0] dsr;
  logic [15:0] rem;
  logic [4:0]  step;
  logic [16:0] trial;
  logic [15:0] rem_next;

  always_comb begin
    trial    = {rem, shreg[31]};
    rem_next = (trial >= {1'b0, dsr}) ? 16'(trial - {1'b0, dsr}) : trial[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= 5'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= 5'd0;
      end else if (busy) begin
        step <= step + 5'd1;
        if (step == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      dsr   <= divisor;
      rem   <= 16'd0;
    end else if (busy) begin
      shreg <= {shreg[30:0], 1'b0};
      rem   <= rem_next;
    end
  end

  assign rem_zero = (rem == 16'd0);
endmodule

// ----- src/wpp_engine.sv -----
// parser engine: header checks, chunk walk and sample assembly
`include "wav_pcm_stream_parser_assert.svh"
module wpp_engine #(
  parameter int POSITION_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [31:0]        first_frame,
  input  logic [31:0]        stop_frame,
  input  logic               in_valid,
  input  wpp_pkg::in_item_t  in_item,
  output logic               in_take,
  input  logic               out_room,
  output wpp_pkg::res_ctl_t  res_ctl,
  output wpp_pkg::out_item_t res0,
  output wpp_pkg::out_item_t res1
);
  wpp_pkg::phase_t phase, phase_next;
  logic [POSITION_BITS-1:0] byte_position, byte_position_next;
  logic [POSITION_BITS-1:0] riff_end, riff_end_next;
  logic [5:0]  fmt_length, fmt_length_next;
  logic [14:0] channel_count, channel_count_next;
  logic [15:0] block_bytes, block_bytes_next;
  logic [1:0]  nbytes, nbytes_next;
  logic [31:0] chunk_remaining, chunk_remaining_next;
  logic [31:0] mark_shift, mark_shift_next;
  logic [31:0] size_acc, size_acc_next;
  logic [31:0] frame_counter, frame_counter_next;
  logic [14:0] channel_counter, channel_counter_next;
  logic [23:0] sample_assembly, sample_assembly_next;
  logic [1:0]  sample_byte_index, sample_byte_index_next;
  logic [31:0] emitted_count, emitted_count_next;
  logic        chk_eof, chk_eof_next;

  logic        div_start, div_busy, div_done, div_zero;
  logic [31:0] ms;
  logic [31:0] sz;
  logic [15:0] hi;
  logic [23:0] asm_new;
  logic [2:0]  idx_inc;
  logic [14:0] ch_inc;
  logic [16:0] frame_bytes;
  logic        in_range;
  logic        samp_now, evt_now, fin_now, eof_now, chunk_end_now;
  logic [3:0]  evt_code;
  logic        evt_fail;
  logic [31:0] samp_val;
  wpp_pkg::out_item_t samp_r, evt_r, fin_r;

  wpp_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (size_acc_next),
    .divisor  (block_bytes),
    .busy     (div_busy),
    .done     (div_done),
    .rem_zero (div_zero)
  );

  always_comb begin
    phase_next             = phase;
    byte_position_next     = byte_position;
    riff_end_next          = riff_end;
    fmt_length_next        = fmt_length;
    channel_count_next     = channel_count;
    block_bytes_next       = block_bytes;
    nbytes_next            = nbytes;
    chunk_remaining_next   = chunk_remaining;
    mark_shift_next        = mark_shift;
    size_acc_next          = size_acc;
    frame_counter_next     = frame_counter;
    channel_counter_next   = channel_counter;
    sample_assembly_next   = sample_assembly;
    sample_byte_index_next = sample_byte_index;
    emitted_count_next     = emitted_count;
    chk_eof_next           = chk_eof;
    in_take       = 1'b0;
    div_start     = 1'b0;
    samp_now      = 1'b0;
    evt_now       = 1'b0;
    evt_fail      = 1'b0;
    evt_code      = wpp_pkg::ERR_RIFF;
    eof_now       = 1'b0;
    chunk_end_now = 1'b0;
    samp_val      = 32'd0;
    in_range      = 1'b0;
    ms      = {in_item.data_byte, mark_shift[31:8]};
    sz      = {in_item.data_byte, size_acc[31:8]};
    hi      = ms[31:16];
    asm_new = sample_assembly;
    case (sample_byte_index)
      2'd0:    asm_new[7:0]   = sample_assembly[7:0]   | in_item.data_byte;
      2'd1:    asm_new[15:8]  = sample_assembly[15:8]  | in_item.data_byte;
      2'd2:    asm_new[23:16] = sample_assembly[23:16] | in_item.data_byte;
      default: asm_new        = sample_assembly;
    endcase
    idx_inc     = {1'b0, sample_byte_index} + 3'd1;
    ch_inc      = channel_counter + 15'd1;
    frame_bytes = 17'(channel_count) * 17'(nbytes);

    if (phase == wpp_pkg::PH_CHECK) begin
      if (div_done) begin
        eof_now = chk_eof;
        if (!div_zero) begin
          evt_now  = 1'b1;
          evt_fail = 1'b1;
          evt_code = wpp_pkg::ERR_ALIGN;
        end else if (frame_bytes != {1'b0, block_bytes}) begin
          evt_now  = 1'b1;
          evt_fail = 1'b1;
          evt_code = wpp_pkg::ERR_BLOCK;
        end else begin
          phase_next             = wpp_pkg::PH_DATA;
          channel_counter_next   = 15'd0;
          sample_assembly_next   = 24'd0;
          sample_byte_index_next = 2'd0;
          chunk_remaining_next   = size_acc;
          if (size_acc == 32'd0) chunk_end_now = 1'b1;
        end
      end
    end else if (in_valid && out_room) begin
      in_take = 1'b1;
      eof_now = in_item.end_of_file;
      if (phase != wpp_pkg::PH_HALT) begin
        byte_position_next = byte_position + POSITION_BITS'(1);
        case (phase)
          wpp_pkg::PH_HEADER: begin
            mark_shift_next = ms;
            case (byte_position[5:0])
              wpp_pkg::POS_RIFF_MARK: begin
                if (ms != wpp_pkg::MARK_RIFF) begin
                  evt_now = 1'b1; evt_fail = 1'b1; evt_code = wpp_pkg::ERR_RIFF;
                end
              end
              wpp_pkg::POS_RIFF_SIZE: riff_end_next = POSITION_BITS'({1'b0, ms} + 33'd8);
              wpp_pkg::POS_WAVE_MARK: begin
                if (ms != wpp_pkg::MARK_WAVE) begin
                  evt_now = 1'b1; evt_fail = 1'b1; evt_code = wpp_pkg::ERR_WAVE;
                end
              end
              wpp_pkg::POS_FMT_MARK: begin
                if (ms != wpp_pkg::MARK_FMT) begin
                  evt_now = 1'b1; evt_fail = 1'b1; evt_code = wpp_pkg::ERR_FMT_MARK;
                end
              end
              wpp_pkg::POS_FMT_SIZE: begin
                if (ms == wpp_pkg::FMT_LEN_16 || ms == wpp_pkg::FMT_LEN_18 ||
                    ms == wpp_pkg::FMT_LEN_40) begin
                  fmt_length_next = ms[5:0];
                end else begin
                  evt_now = 1'b1; evt_fail = 1'b1; evt_code = wpp_pkg::ERR_FMT_SIZE;
                end
              end
              wpp_pkg::POS_TAG: begin
                if (hi != wpp_pkg::TAG_PCM && hi != wpp_pkg::TAG_EXTENSIBLE) begin
                  evt_now = 1'b1; evt_fail = 1'b1; evt_code = wpp_pkg::ERR_TAG;
                end
              end
              wpp_pkg::POS_CHANNELS: begin
                if (hi == 16'd0 || hi[15]) begin
                  evt_now = 1'b1; evt_fail = 1'b1; evt_code = wpp_pkg::ERR_CHANNELS;
                end else begin
                  channel_count_next = hi[14:0];
                end
              end
              wpp_pkg::POS_BLOCK: block_bytes_next = hi;
              wpp_pkg::POS_BITS: begin
                if (hi == wpp_pkg::BITS_8 || hi == wpp_pkg::BITS_16 ||
                    hi == wpp_pkg::BITS_24) begin
                  nbytes_next = hi[4:3];
                  if (fmt_length > 6'd16) begin
                    phase_next           = wpp_pkg::PH_EXT;
                    chunk_remaining_next = 32'(fmt_length - 6'd16);
                  end else begin
                    phase_next           = wpp_pkg::PH_CHUNK;
                    chunk_remaining_next = 32'd0;
                  end
                end else begin
                  evt_now = 1'b1; evt_fail = 1'b1; evt_code = wpp_pkg::ERR_BITS;
                end
              end
              default: ;
            endcase
          end
          wpp_pkg::PH_EXT: begin
            chunk_remaining_next = chunk_remaining - 32'd1;
            if (chunk_remaining_next == 32'd0) phase_next = wpp_pkg::PH_CHUNK;
          end
          wpp_pkg::PH_CHUNK: begin
            if (chunk_remaining < 32'd4) mark_shift_next = ms;
            else size_acc_next = sz;
            chunk_remaining_next = chunk_remaining + 32'd1;
            if (chunk_remaining == 32'd7) begin
              if (mark_shift == wpp_pkg::MARK_DATA) begin
                if (block_bytes == 16'd0) begin
                  evt_now = 1'b1; evt_fail = 1'b1; evt_code = wpp_pkg::ERR_ALIGN;
                end else begin
                  // alignment check runs in the remainder unit, byte result waits
                  phase_next   = wpp_pkg::PH_CHECK;
                  div_start    = 1'b1;
                  chk_eof_next = in_item.end_of_file;
                  eof_now      = 1'b0;
                end
              end else begin
                phase_next           = wpp_pkg::PH_SKIP;
                chunk_remaining_next = sz;
                if (sz == 32'd0) chunk_end_now = 1'b1;
              end
            end
          end
          wpp_pkg::PH_SKIP: begin
            chunk_remaining_next = chunk_remaining - 32'd1;
            if (chunk_remaining_next == 32'd0) chunk_end_now = 1'b1;
          end
          wpp_pkg::PH_DATA: begin
            if (idx_inc >= {1'b0, nbytes}) begin
              in_range = (frame_counter >= first_frame) && (frame_counter < stop_frame);
              case (nbytes)
                2'd1:    samp_val = {{24{asm_new[7]}}, asm_new[7:0]};
                2'd2:    samp_val = {{16{asm_new[15]}}, asm_new[15:0]};
                default: samp_val = {asm_new, 8'h00};
              endcase
              samp_now = in_range;
              if (ch_inc >= channel_count) begin
                channel_counter_next = 15'd0;
                if (in_range) emitted_count_next = emitted_count + 32'd1;
                frame_counter_next = frame_counter + 32'd1;
              end else begin
                channel_counter_next = ch_inc;
              end
              sample_assembly_next   = 24'd0;
              sample_byte_index_next = 2'd0;
            end else begin
              sample_assembly_next   = asm_new;
              sample_byte_index_next = idx_inc[1:0];
            end
            chunk_remaining_next = chunk_remaining - 32'd1;
            if (chunk_remaining_next == 32'd0) chunk_end_now = 1'b1;
          end
          default: ;
        endcase
      end
    end

    if (chunk_end_now) begin
      if (byte_position_next >= riff_end) begin
        evt_now = 1'b1;
      end else begin
        phase_next           = wpp_pkg::PH_CHUNK;
        chunk_remaining_next = 32'd0;
      end
    end
    if (evt_now) phase_next = wpp_pkg::PH_HALT;
    fin_now = eof_now && (phase_next != wpp_pkg::PH_HALT);

    samp_r             = '0;
    samp_r.kind        = wpp_pkg::KIND_SAMPLE;
    samp_r.sample      = samp_val;
    samp_r.channel     = channel_counter;
    samp_r.frame_index = frame_counter;
    samp_r.sample_bits = nbytes - 2'd1;
    evt_r              = '0;
    evt_r.kind         = evt_fail ? wpp_pkg::KIND_ERROR : wpp_pkg::KIND_DONE;
    evt_r.error_code   = evt_fail ? evt_code : 4'd0;
    evt_r.frames_read  = evt_fail ? 32'd0 : emitted_count_next;
    fin_r              = '0;
    fin_r.kind         = wpp_pkg::KIND_DONE;
    fin_r.frames_read  = emitted_count_next;

    res_ctl.room = out_room;
    res_ctl.cnt  = {1'b0, samp_now} + {1'b0, evt_now} + {1'b0, fin_now};
    res0 = samp_now ? samp_r : (evt_now ? evt_r : fin_r);
    res1 = (samp_now && evt_now) ? evt_r : fin_r;
    if (res_ctl.cnt == 2'd1) res0.last = 1'b1;
    if (res_ctl.cnt == 2'd2) res1.last = 1'b1;

    // end of file rearms the parser for the next file
    if (eof_now) begin
      phase_next             = wpp_pkg::PH_HEADER;
      byte_position_next     = '0;
      riff_end_next          = '0;
      fmt_length_next        = 6'd0;
      channel_count_next     = 15'd0;
      block_bytes_next       = 16'd0;
      nbytes_next            = 2'd0;
      chunk_remaining_next   = 32'd0;
      mark_shift_next        = 32'd0;
      size_acc_next          = 32'd0;
      frame_counter_next     = 32'd0;
      channel_counter_next   = 15'd0;
      sample_assembly_next   = 24'd0;
      sample_byte_index_next = 2'd0;
      emitted_count_next     = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= wpp_pkg::PH_HEADER;
      byte_position     <= '0;
      riff_end          <= '0;
      fmt_length        <= 6'd0;
      channel_count     <= 15'd0;
      block_bytes       <= 16'd0;
      nbytes            <= 2'd0;
      chunk_remaining   <= 32'd0;
      mark_shift        <= 32'd0;
      size_acc          <= 32'd0;
      frame_counter     <= 32'd0;
      channel_counter   <= 15'd0;
      sample_assembly   <= 24'd0;
      sample_byte_index <= 2'd0;
      emitted_count     <= 32'd0;
      chk_eof           <= 1'b0;
    end else begin
      phase             <= phase_next;
      byte_position     <= byte_position_next;
      riff_end          <= riff_end_next;
      fmt_length        <= fmt_length_next;
      channel_count     <= channel_count_next;
      block_bytes       <= block_bytes_next;
      nbytes            <= nbytes_next;
      chunk_remaining   <= chunk_remaining_next;
      mark_shift        <= mark_shift_next;
      size_acc          <= size_acc_next;
      frame_counter     <= frame_counter_next;
      channel_counter   <= channel_counter_next;
      sample_assembly   <= sample_assembly_next;
      sample_byte_index <= sample_byte_index_next;
      emitted_count     <= emitted_count_next;
      chk_eof           <= chk_eof_next;
    end
  end

  `WPP_ASSERT_IMP(a_check_has_div, clk, rst, phase == wpp_pkg::PH_CHECK, div_busy || div_done)
  `WPP_ASSERT_IMP(a_push_has_room, clk, rst, res_ctl.cnt != 2'd0, out_room)
  `WPP_ASSERT_NXT(a_halt_holds, clk, rst, phase == wpp_pkg::PH_HALT && !in_take, phase == wpp_pkg::PH_HALT)
endmodule

// ----- src/wav_pcm_stream_parser.sv -----
// top level of the wav pcm stream parser
// A WAV file enters one byte per transaction on the input queue (push/full,
// in_item with data_byte and end_of_file). Results leave through the result
// queue (empty/pop, out_item): samples, one error, or done with frames_read.
// first_frame and stop_frame are written on cfg_we/cfg_addr/cfg_data and
// select the emitted frame range; write them only while the block is idle,
// which the block itself does not enforce. Throughput: one byte per cycle
// while the result queue has room. The eighth byte of a data chunk header
// starts the remainder unit for the alignment check, and no further byte is
// taken until that check is done. A result enters the result queue on the
// edge that accepts its byte, or on the edge that ends the alignment check.
// The two-entry input queue and four-entry result queue sit on either side
// of the engine; the engine takes a byte only while the result queue has
// room for two results, so a stalled receiver fills the result queue and
// then the input queue, and full rises.
// Reset clears both queues and the parser, and sets first_frame to 0 and
// stop_frame to all ones. After end_of_file the parser starts a new file.
module wav_pcm_stream_parser #(
  parameter int POSITION_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  wpp_pkg::in_item_t  in_item,
  output logic               empty,
  input  logic               pop,
  output wpp_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic               cfg_addr,
  input  logic [31:0]        cfg_data
);
  logic [31:0] first_frame;
  logic [31:0] stop_frame;
  logic        q_valid;
  logic        q_take;
  logic        out_room;
  wpp_pkg::in_item_t  q_item;
  wpp_pkg::res_ctl_t  res_ctl;
  wpp_pkg::out_item_t res0;
  wpp_pkg::out_item_t res1;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_frame <= 32'd0;
      stop_frame  <= 32'hFFFF_FFFF;
    end else if (cfg_we) begin
      if (cfg_addr == wpp_pkg::CFG_FIRST_FRAME) first_frame <= cfg_data;
      if (cfg_addr == wpp_pkg::CFG_STOP_FRAME) stop_frame <= cfg_data;
    end
  end

  wpp_inq u_inq (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (in_item),
    .full  (full),
    .take  (q_take),
    .valid (q_valid),
    .dout  (q_item)
  );

  wpp_engine #(
    .POSITION_BITS (POSITION_BITS)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .first_frame (first_frame),
    .stop_frame  (stop_frame),
    .in_valid    (q_valid),
    .in_item     (q_item),
    .in_take     (q_take),
    .out_room    (out_room),
    .res_ctl     (res_ctl),
    .res0        (res0),
    .res1        (res1)
  );

  wpp_outq u_outq (
    .clk    (clk),
    .rst    (rst),
    .push_n (res_ctl.cnt),
    .d0     (res0),
    .d1     (res1),
    .room   (out_room),
    .pop    (pop),
    .empty  (empty),
    .dout   (out_item)
  );
endmodule
